### rtl/smrp_pkg.sv
// Shared types and constants for the SGR mouse report parser.
package smrp_pkg;

  localparam int unsigned CoordBitsDefault = 16;
  localparam int unsigned PosWidth         = 16;
  localparam int unsigned TimeoutWidth     = 16;
  localparam logic [TimeoutWidth-1:0] TimeoutReset = 16'd100;

  localparam logic       CmdByte   = 1'b0;
  localparam logic       CmdTick   = 1'b1;
  localparam logic       KindKey   = 1'b0;
  localparam logic       KindMouse = 1'b1;

  localparam logic [7:0] ChEsc     = 8'h1b;
  localparam logic [7:0] ChLBrack  = 8'h5b;
  localparam logic [7:0] ChLt      = 8'h3c;
  localparam logic [7:0] ChSemi    = 8'h3b;
  localparam logic [7:0] ChPress   = 8'h4d;
  localparam logic [7:0] ChRelease = 8'h6d;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;

  // Byte class decided in the front end.
  typedef enum logic [3:0] {
    CLS_TICK,
    CLS_ESC,
    CLS_LBRACK,
    CLS_LT,
    CLS_SEMI,
    CLS_DIGIT,
    CLS_PRESS,
    CLS_RELEASE,
    CLS_OTHER
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [7:0] byte_value;
    logic [3:0] digit;
  } token_t;

endpackage

### rtl/smrp_in_if.sv
// Request channel: received byte or idle tick.
interface smrp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] byte_value;

  modport source (output valid, output command, output byte_value, input ready);
  modport sink   (input valid, input command, input byte_value, output ready);
endinterface

### rtl/smrp_out_if.sv
// Event channel: keyboard or mouse event.
interface smrp_out_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic [7:0]  key_code;
  logic [1:0]  button;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic        pressed;

  modport source (output valid, output event_kind, output key_code, output button,
                  output pos_x, output pos_y, output pressed, input ready);
  modport sink   (input valid, input event_kind, input key_code, input button,
                  input pos_x, input pos_y, input pressed, output ready);
endinterface

### rtl/smrp_front.sv
// Front end: classify each request and hold it in a two-entry token queue.
module smrp_front
  import smrp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  smrp_in_if.sink      req_i,
  output logic         tok_valid_o,
  output token_t       tok_o,
  input  logic         tok_pop_i
);

  token_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  token_t     tok_new;
  logic       push, pop;

  always_comb begin
    tok_new.byte_value = req_i.byte_value;
    tok_new.digit      = 4'(req_i.byte_value - ChZero);
    if (req_i.command == CmdTick) begin
      tok_new.cls = CLS_TICK;
    end else if (req_i.byte_value == ChEsc) begin
      tok_new.cls = CLS_ESC;
    end else if (req_i.byte_value == ChLBrack) begin
      tok_new.cls = CLS_LBRACK;
    end else if (req_i.byte_value == ChLt) begin
      tok_new.cls = CLS_LT;
    end else if (req_i.byte_value == ChSemi) begin
      tok_new.cls = CLS_SEMI;
    end else if (req_i.byte_value inside {[ChZero:ChNine]}) begin
      tok_new.cls = CLS_DIGIT;
    end else if (req_i.byte_value == ChPress) begin
      tok_new.cls = CLS_PRESS;
    end else if (req_i.byte_value == ChRelease) begin
      tok_new.cls = CLS_RELEASE;
    end else begin
      tok_new.cls = CLS_OTHER;
    end
  end

  assign req_i.ready = (count_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign tok_valid_o = (count_q != 2'd0);
  assign pop         = tok_pop_i && tok_valid_o;
  assign tok_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= tok_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### rtl/smrp_back.sv
// Back end: report parser state machine with the event output register.
module smrp_back
  import smrp_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    tok_valid_i,
  input  token_t                  tok_i,
  output logic                    tok_pop_o,
  input  logic [TimeoutWidth-1:0] timeout_ticks_i,
  smrp_out_if.source              evt_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ESC,
    ST_BRACKET,
    ST_BUTTON,
    ST_COLUMN,
    ST_ROW
  } state_e;

  localparam int unsigned AccW = COORD_BITS + 4;
  localparam logic [AccW-1:0] CoordMax = {4'b0, {COORD_BITS{1'b1}}};

  state_e                  state_q;
  logic [1:0]              button_q;
  logic [COORD_BITS-1:0]   col_q, row_q;
  logic [TimeoutWidth-1:0] wait_q, wait_inc;
  logic                    out_valid_q;
  logic                    out_kind_q, out_pressed_q;
  logic [7:0]              out_key_q;
  logic [1:0]              out_button_q;
  logic [15:0]             out_x_q, out_y_q;

  logic [AccW-1:0]         acc_ext, acc_mul;
  logic [COORD_BITS-1:0]   acc_sat;
  logic [COORD_BITS+15:0]  col_wide, row_wide;

  assign tok_pop_o = tok_valid_i && (!out_valid_q || evt_o.ready);

  // Digit step for whichever coordinate is being read; saturate at the max.
  always_comb begin
    acc_ext = {4'b0, (state_q == ST_COLUMN) ? col_q : row_q};
    acc_mul = (acc_ext << 3) + (acc_ext << 1) + AccW'(tok_i.digit);
    acc_sat = (acc_mul > CoordMax) ? CoordMax[COORD_BITS-1:0] : acc_mul[COORD_BITS-1:0];
  end

  assign wait_inc = (wait_q == '1) ? wait_q : wait_q + 1'b1;
  assign col_wide = {16'b0, col_q};
  assign row_wide = {16'b0, row_q};

  assign evt_o.valid      = out_valid_q;
  assign evt_o.event_kind = out_kind_q;
  assign evt_o.key_code   = out_key_q;
  assign evt_o.button     = out_button_q;
  assign evt_o.pos_x      = out_x_q;
  assign evt_o.pos_y      = out_y_q;
  assign evt_o.pressed    = out_pressed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      button_q      <= '0;
      col_q         <= '0;
      row_q         <= '0;
      wait_q        <= '0;
      out_valid_q   <= 1'b0;
      out_kind_q    <= KindKey;
      out_key_q     <= '0;
      out_button_q  <= '0;
      out_x_q       <= '0;
      out_y_q       <= '0;
      out_pressed_q <= 1'b0;
    end else begin
      if (evt_o.ready) out_valid_q <= 1'b0;
      if (tok_pop_o) begin
        if (tok_i.cls == CLS_TICK) begin
          if (state_q != ST_IDLE) begin
            if (wait_inc >= timeout_ticks_i) begin
              state_q  <= ST_IDLE;
              button_q <= '0;
              col_q    <= '0;
              row_q    <= '0;
              wait_q   <= '0;
            end else begin
              wait_q <= wait_inc;
            end
          end
        end else begin
          wait_q <= '0;
          // Drop the report by default; each phase overrides on a good byte.
          state_q  <= ST_IDLE;
          button_q <= '0;
          col_q    <= '0;
          row_q    <= '0;
          case (state_q)
            ST_IDLE: begin
              if (tok_i.cls == CLS_ESC) begin
                state_q <= ST_ESC;
              end else begin
                out_valid_q   <= 1'b1;
                out_kind_q    <= KindKey;
                out_key_q     <= tok_i.byte_value;
                out_button_q  <= '0;
                out_x_q       <= '0;
                out_y_q       <= '0;
                out_pressed_q <= 1'b0;
              end
            end
            ST_ESC: begin
              if (tok_i.cls == CLS_LBRACK) state_q <= ST_BRACKET;
            end
            ST_BRACKET: begin
              if (tok_i.cls == CLS_LT) state_q <= ST_BUTTON;
            end
            ST_BUTTON: begin
              if (tok_i.cls == CLS_SEMI) begin
                state_q  <= ST_COLUMN;
                button_q <= button_q;
              end else if (tok_i.cls == CLS_DIGIT) begin
                state_q  <= ST_BUTTON;
                button_q <= {button_q[0], 1'b0} + tok_i.digit[1:0];
              end
            end
            ST_COLUMN: begin
              if (tok_i.cls inside {CLS_SEMI, CLS_DIGIT}) begin
                button_q <= button_q;
                col_q    <= (tok_i.cls == CLS_DIGIT) ? acc_sat : col_q;
                state_q  <= (tok_i.cls == CLS_SEMI) ? ST_ROW : ST_COLUMN;
              end
            end
            ST_ROW: begin
              if (tok_i.cls inside {CLS_PRESS, CLS_RELEASE}) begin
                out_valid_q   <= 1'b1;
                out_kind_q    <= KindMouse;
                out_key_q     <= '0;
                out_button_q  <= button_q;
                out_x_q       <= col_wide[15:0];
                out_y_q       <= row_wide[15:0];
                out_pressed_q <= (tok_i.cls == CLS_PRESS);
              end else if (tok_i.cls == CLS_DIGIT) begin
                state_q  <= ST_ROW;
                button_q <= button_q;
                col_q    <= col_q;
                row_q    <= acc_sat;
              end
            end
            default: state_q <= ST_IDLE;
          endcase
        end
      end
    end
  end

endmodule

### rtl/sgr_mouse_report_parser.sv
// Top level of the SGR mouse report parser.
//
//   channel  dir  handshake           payload
//   req_i    in   valid/ready         command, byte_value
//   evt_o    out  valid/ready         event_kind, key_code, button, pos_x, pos_y, pressed
//   cfg      in   cfg_we_i            cfg_wdata_i -> timeout_ticks
//
// One request per cycle is taken while the token queue has room; an accepted request
// is queued as a token, then parsed into the event output register when popped.
// The parser holds while an event waits to be taken; the two-entry token queue
// keeps taking requests until it fills, then ready drops.
// Reset clears the parser to idle and sets timeout_ticks to 100.
module sgr_mouse_report_parser
  import smrp_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  smrp_in_if.sink                 req_i,
  smrp_out_if.source              evt_o,
  input  logic                    cfg_we_i,
  input  logic [TimeoutWidth-1:0] cfg_wdata_i
);

  logic [TimeoutWidth-1:0] timeout_q;
  logic                    tok_valid, tok_pop;
  token_t                  tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  smrp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_pop_i   (tok_pop)
  );

  smrp_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tok_valid_i     (tok_valid),
    .tok_i           (tok),
    .tok_pop_o       (tok_pop),
    .timeout_ticks_i (timeout_q),
    .evt_o           (evt_o)
  );

endmodule

### sim/sgr_mouse_report_parser_tb.sv
// Self-checking testbench for the SGR mouse report parser with a behavioral predictor.
module sgr_mouse_report_parser_tb;
  import smrp_pkg::*;

  localparam int unsigned PhaseReqs  = 290;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ShowErrors = 10;
  localparam longint unsigned CoordMax = (64'd1 << CoordBitsDefault) - 1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ESC,
    PH_BRACKET,
    PH_BUTTON,
    PH_COLUMN,
    PH_ROW
  } parse_phase_e;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
  } term_req_t;

  typedef struct packed {
    logic                kind;
    logic [7:0]          key;
    logic [1:0]          button;
    logic [PosWidth-1:0] pos_x;
    logic [PosWidth-1:0] pos_y;
    logic                pressed;
  } term_event_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we;
  logic [TimeoutWidth-1:0] cfg_wdata;

  smrp_in_if  req_if ();
  smrp_out_if evt_if ();

  sgr_mouse_report_parser i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .evt_o      (evt_if),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  term_req_t   pending_reqs[$];
  term_event_t expected_events[$];
  int unsigned reqs_built;
  int unsigned error_count;
  int unsigned cycle_count;
  bit          no_stalls;

  // Parser state as the predictor sees it
  logic [TimeoutWidth-1:0] timeout_cfg;
  parse_phase_e            rep_phase;
  logic [1:0]              rep_button;
  longint unsigned         rep_col;
  longint unsigned         rep_row;
  logic [15:0]             rep_wait;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void drop_report();
    rep_phase  = PH_IDLE;
    rep_button = '0;
    rep_col    = 0;
    rep_row    = 0;
    rep_wait   = '0;
  endfunction

  function automatic longint unsigned add_digit(longint unsigned acc, logic [3:0] d);
    longint unsigned v;
    v = acc * 10 + d;
    return (v > CoordMax) ? CoordMax : v;
  endfunction

  // Advance the parser by one request; return 1 when it yields an event.
  function automatic bit decode_request(input logic cmd, input logic [7:0] b,
                                        output term_event_t ev);
    bit         is_digit;
    logic [3:0] d;
    ev       = '0;
    is_digit = b inside {[ChZero:ChNine]};
    d        = 4'(b - ChZero);
    if (cmd == CmdTick) begin
      if (rep_phase != PH_IDLE) begin
        if (rep_wait != 16'hFFFF) rep_wait++;
        if (rep_wait >= timeout_cfg) drop_report();
      end
      return 1'b0;
    end
    rep_wait = '0;
    case (rep_phase)
      PH_IDLE: begin
        if (b == ChEsc) begin
          rep_phase = PH_ESC;
          return 1'b0;
        end
        ev.kind = KindKey;
        ev.key  = b;
        return 1'b1;
      end
      PH_ESC: begin
        if (b == ChLBrack) rep_phase = PH_BRACKET;
        else drop_report();
      end
      PH_BRACKET: begin
        if (b == ChLt) rep_phase = PH_BUTTON;
        else drop_report();
      end
      PH_BUTTON: begin
        if (b == ChSemi) rep_phase = PH_COLUMN;
        else if (is_digit) rep_button = 2'({rep_button, 1'b0} + d);
        else drop_report();
      end
      PH_COLUMN: begin
        if (b == ChSemi) rep_phase = PH_ROW;
        else if (is_digit) rep_col = add_digit(rep_col, d);
        else drop_report();
      end
      PH_ROW: begin
        if (b inside {ChPress, ChRelease}) begin
          ev.kind    = KindMouse;
          ev.button  = rep_button;
          ev.pos_x   = rep_col[PosWidth-1:0];
          ev.pos_y   = rep_row[PosWidth-1:0];
          ev.pressed = (b == ChPress);
          drop_report();
          return 1'b1;
        end
        if (is_digit) rep_row = add_digit(rep_row, d);
        else drop_report();
      end
      default: drop_report();
    endcase
    return 1'b0;
  endfunction

  function automatic void note_mismatch(string what, term_event_t want, term_event_t got);
    error_count++;
    if (error_count <= ShowErrors) begin
      $display("ERROR: %s at cycle %0d", what, cycle_count);
      $display("  expected kind=%0d key=%02h button=%0d x=%0d y=%0d pressed=%0d",
               want.kind, want.key, want.button, want.pos_x, want.pos_y, want.pressed);
      $display("  actual   kind=%0d key=%02h button=%0d x=%0d y=%0d pressed=%0d",
               got.kind, got.key, got.button, got.pos_x, got.pos_y, got.pressed);
    end
  endfunction

  // Request stimulus builders

  function automatic void push_byte(logic [7:0] b);
    pending_reqs.push_back('{command: CmdByte, byte_value: b});
    reqs_built++;
  endfunction

  function automatic void push_ticks(int unsigned n);
    repeat (n) begin
      pending_reqs.push_back('{command: CmdTick, byte_value: 8'($urandom_range(0, 255))});
      reqs_built++;
    end
  endfunction

  function automatic int unsigned pause_len();
    if ($urandom_range(0, 29) == 0 && timeout_cfg <= 200)
      return timeout_cfg - 1 + $urandom_range(0, 1);
    return $urandom_range(1, 6);
  endfunction

  function automatic logic [7:0] pick_bad();
    case ($urandom_range(0, 6))
      0: return ChEsc;
      1: return ChSemi;
      2: return ChPress;
      3: return ChRelease;
      4: return ChLBrack;
      5: return ChLt;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_number(ref logic [7:0] seq[$]);
    int unsigned ndig;
    bit          nines;
    ndig  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
    nines = ($urandom_range(0, 7) == 0);
    repeat (ndig) seq.push_back(nines ? ChNine : 8'(ChZero + $urandom_range(0, 9)));
  endfunction

  // Well-formed report with random content; a broken one gets a bad byte and is cut there.
  function automatic void push_report(bit broken);
    logic [7:0]  seq[$];
    int unsigned cut;
    seq = {ChEsc, ChLBrack, ChLt};
    add_number(seq);
    seq.push_back(ChSemi);
    add_number(seq);
    seq.push_back(ChSemi);
    add_number(seq);
    seq.push_back($urandom_range(0, 1) ? ChPress : ChRelease);
    if (broken) begin
      cut      = $urandom_range(1, seq.size() - 1);
      seq[cut] = pick_bad();
      seq      = seq[0:cut];
    end
    foreach (seq[i]) begin
      if (i > 0 && $urandom_range(0, 99) < 20) push_ticks(pause_len());
      push_byte(seq[i]);
    end
  endfunction

  function automatic void push_random(int unsigned count);
    int unsigned goal;
    int unsigned r;
    goal = reqs_built + count;
    while (reqs_built < goal) begin
      r = $urandom_range(0, 99);
      if (r < 60) push_report(1'b0);
      else if (r < 72) push_report(1'b1);
      else if (r < 88) push_byte(8'($urandom_range(0, 255)));
      else push_ticks($urandom_range(1, 4));
    end
  endfunction

  function automatic void push_directed();
    // Idle tick, key extremes
    push_ticks(1);
    push_byte(8'h00);
    push_byte(8'hFF);
    // Empty button, column and row; release
    push_byte(ChEsc); push_byte(ChLBrack); push_byte(ChLt);
    push_byte(ChSemi); push_byte(ChSemi); push_byte(ChRelease);
    // Large button, saturated column, press
    push_byte(ChEsc); push_byte(ChLBrack); push_byte(ChLt);
    push_byte(8'h37); push_byte(ChSemi);
    repeat (6) push_byte(ChNine);
    push_byte(ChSemi); push_byte(8'h35); push_byte(ChPress);
    // Bad byte after ESC, then a terminator inside the button field
    push_byte(ChEsc); push_byte(8'h58);
    push_byte(ChEsc); push_byte(ChLBrack); push_byte(ChLt); push_byte(ChPress);
  endfunction

  task automatic set_timeout(logic [TimeoutWidth-1:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    timeout_cfg = v;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || req_if.valid || expected_events.size() != 0);
    // Let swallowed bytes still in the pipeline settle
    repeat (8) @(negedge clk_i);
  endtask

  // Request driver
  always @(posedge clk_i) begin : drive_req
    term_req_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_reqs.size() != 0 && (no_stalls || $urandom_range(0, 99) >= 15)) begin
        nxt = pending_reqs.pop_front();
        req_if.valid      <= 1'b1;
        req_if.command    <= nxt.command;
        req_if.byte_value <= nxt.byte_value;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Event sink back-pressure
  always @(posedge clk_i) begin
    evt_if.ready <= rst_ni && (no_stalls || $urandom_range(0, 99) >= 15);
  end

  // Check events first, then predict from the request taken at this edge
  always @(posedge clk_i) begin : watch
    term_event_t got;
    term_event_t want;
    term_event_t pred;
    if (rst_ni) begin
      if (evt_if.valid && evt_if.ready) begin
        got.kind    = evt_if.event_kind;
        got.key     = evt_if.key_code;
        got.button  = evt_if.button;
        got.pos_x   = evt_if.pos_x;
        got.pos_y   = evt_if.pos_y;
        got.pressed = evt_if.pressed;
        if (expected_events.size() == 0) begin
          note_mismatch("event with none expected", '0, got);
        end else begin
          want = expected_events.pop_front();
          if (got !== want) note_mismatch("event mismatch", want, got);
        end
      end
      if (req_if.valid && req_if.ready) begin
        if (decode_request(req_if.command, req_if.byte_value, pred))
          expected_events.push_back(pred);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : run
    logic [TimeoutWidth-1:0] next_timeout [4];
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.command    = CmdByte;
    req_if.byte_value = '0;
    evt_if.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    no_stalls         = 1'b0;
    reqs_built        = 0;
    error_count       = 0;
    cycle_count       = 0;
    timeout_cfg       = TimeoutReset;
    drop_report();
    next_timeout = '{16'd1, 16'hFFFF, 16'd5, 16'($urandom_range(2, 40))};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_directed();
    push_random(PhaseReqs - reqs_built);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      set_timeout(next_timeout[p]);
      no_stalls = (p == 1);
      @(negedge clk_i);
      if (p == 0) begin
        // Tick inside a report times it out; the next byte is a plain key
        push_byte(ChEsc); push_byte(ChLBrack); push_ticks(1); push_byte(8'h41);
      end
      push_random(PhaseReqs);
      wait_drained();
      no_stalls = 1'b0;
    end

    error_count += expected_events.size();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sgr_mouse_report_parser.f
rtl/smrp_pkg.sv
rtl/smrp_in_if.sv
rtl/smrp_out_if.sv
rtl/smrp_front.sv
rtl/smrp_back.sv
rtl/sgr_mouse_report_parser.sv
sim/sgr_mouse_report_parser_tb.sv
